// ===== design/nibc_pkg.sv =====
// ----------------------------------------------------------------------------
// nibc_pkg
// shared opcodes, wire-format constants and types for the integer byte codec
// ----------------------------------------------------------------------------
package nibc_pkg;

  typedef enum logic [1:0] {
    OP_ENC_COMPACT = 2'd0,
    OP_ENC_VARINT  = 2'd1,
    OP_DEC_COMPACT = 2'd2,
    OP_DEC_VARINT  = 2'd3
  } opcode_t;

  localparam logic [7:0] MARK_SHORT = 8'h80;
  localparam logic [7:0] MARK_LONG  = 8'h81;
  localparam logic [7:0] CONT_BIT   = 8'h80;

  localparam logic [2:0] COMPACT_SHORT_LEN = 3'd3;
  localparam logic [2:0] COMPACT_LONG_LEN  = 3'd5;
  localparam logic [2:0] VARINT_MAX_LEN    = 3'd4;

  localparam logic signed [31:0] SMALL_MIN = -32'sd126;
  localparam logic signed [31:0] SMALL_MAX = 32'sd127;
  localparam logic signed [31:0] MID_MIN   = -32'sd32768;
  localparam logic signed [31:0] MID_MAX   = 32'sd32767;

  localparam logic [31:0] VARINT_LIM1 = 32'd1 << 7;
  localparam logic [31:0] VARINT_LIM2 = 32'd1 << 14;
  localparam logic [31:0] VARINT_LIM3 = 32'd1 << 21;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } dec_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_beat_t;

endpackage

// ===== design/nibc_enc.sv =====
// ----------------------------------------------------------------------------
// nibc_enc
// picks one byte of the compact or varint encoding of a value by byte index
// ----------------------------------------------------------------------------
module nibc_enc (
  input  logic               varint,
  input  logic signed [31:0] value,
  input  logic [2:0]         idx,
  output nibc_pkg::enc_beat_t beat
);
  import nibc_pkg::*;

  logic       small_range;
  logic       mid_range;
  logic       big_varint;
  logic [2:0] len;
  logic [7:0] cmp_byte;
  logic [7:0] var_byte;
  logic [6:0] group;
  logic [31:0] uval;

  assign uval        = value;
  assign small_range = (value >= SMALL_MIN) && (value <= SMALL_MAX);
  assign mid_range   = (value >= MID_MIN) && (value <= MID_MAX);
  assign big_varint  = uval[31] || (uval >= VARINT_LIM3);

  always_comb begin
    if (varint) begin
      if (big_varint) len = VARINT_MAX_LEN;
      else if (uval < VARINT_LIM1) len = 3'd1;
      else if (uval < VARINT_LIM2) len = 3'd2;
      else len = 3'd3;
    end else begin
      if (small_range) len = 3'd1;
      else if (mid_range) len = COMPACT_SHORT_LEN;
      else len = COMPACT_LONG_LEN;
    end
  end

  always_comb begin
    unique case (idx)
      3'd0: cmp_byte = small_range ? uval[7:0] : (mid_range ? MARK_SHORT : MARK_LONG);
      3'd1: cmp_byte = uval[7:0];
      3'd2: cmp_byte = uval[15:8];
      3'd3: cmp_byte = uval[23:16];
      3'd4: cmp_byte = uval[31:24];
      default: cmp_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (idx)
      3'd0: group = uval[6:0];
      3'd1: group = uval[13:7];
      3'd2: group = uval[20:14];
      default: group = 7'd0;
    endcase
    if (idx == 3'd3) var_byte = uval[28:21];
    else var_byte = (idx < (len - 3'd1)) ? (CONT_BIT | {1'b0, group}) : {1'b0, group};
  end

  assign beat.data = varint ? var_byte : cmp_byte;
  assign beat.last = (idx == (len - 3'd1));

endmodule

// ===== design/nibc_dec.sv =====
// ----------------------------------------------------------------------------
// nibc_dec
// byte-serial decoder state for both formats, one byte per step
// ----------------------------------------------------------------------------
module nibc_dec (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  op_varint,
  input  logic [7:0]            in_byte,
  output nibc_pkg::dec_result_t res
);
  import nibc_pkg::*;

  logic [2:0]  bytes_seen, bytes_seen_next;
  logic        decode_format, decode_format_next;
  logic [31:0] partial_value, partial_value_next;
  logic [2:0]  bytes_expected, bytes_expected_next;
  logic        use_varint;
  logic [2:0]  seen_inc;
  logic [31:0] merged;

  assign use_varint = (bytes_seen != 3'd0) ? decode_format : op_varint;
  assign seen_inc   = bytes_seen + 3'd1;

  always_comb begin
    bytes_seen_next     = bytes_seen;
    decode_format_next  = decode_format;
    partial_value_next  = partial_value;
    bytes_expected_next = bytes_expected;
    res.hit             = 1'b0;
    res.value           = 32'd0;
    merged              = 32'd0;
    if (use_varint) begin
      if (bytes_seen == 3'd0) begin
        if (!in_byte[7]) begin
          res.hit   = 1'b1;
          res.value = {24'd0, in_byte};
        end else begin
          decode_format_next  = 1'b1;
          bytes_expected_next = VARINT_MAX_LEN;
          bytes_seen_next     = 3'd1;
          partial_value_next  = {25'd0, in_byte[6:0]};
        end
      end else if (bytes_seen >= 3'd3) begin
        res.hit   = 1'b1;
        res.value = {{3{in_byte[7]}}, in_byte, partial_value[20:0]};
      end else begin
        if (bytes_seen == 3'd1) merged = partial_value | {18'd0, in_byte[6:0], 7'd0};
        else merged = partial_value | {11'd0, in_byte[6:0], 14'd0};
        if (!in_byte[7]) begin
          res.hit   = 1'b1;
          res.value = merged;
        end else begin
          partial_value_next = merged;
          bytes_seen_next    = seen_inc;
        end
      end
    end else begin
      if (bytes_seen == 3'd0) begin
        if (in_byte == MARK_SHORT || in_byte == MARK_LONG) begin
          decode_format_next  = 1'b0;
          bytes_expected_next = (in_byte == MARK_SHORT) ? COMPACT_SHORT_LEN
                                                        : COMPACT_LONG_LEN;
          bytes_seen_next     = 3'd1;
          partial_value_next  = 32'd0;
        end else begin
          res.hit   = 1'b1;
          res.value = {{24{in_byte[7]}}, in_byte};
        end
      end else begin
        unique case (bytes_seen[1:0])
          2'd1: merged = partial_value | {24'd0, in_byte};
          2'd2: merged = partial_value | {16'd0, in_byte, 8'd0};
          2'd3: merged = partial_value | {8'd0, in_byte, 16'd0};
          2'd0: merged = partial_value | {in_byte, 24'd0};
          default: merged = partial_value;
        endcase
        if (seen_inc < bytes_expected) begin
          partial_value_next = merged;
          bytes_seen_next    = seen_inc;
        end else begin
          res.hit   = 1'b1;
          res.value = (bytes_expected == COMPACT_SHORT_LEN)
                      ? {{16{merged[15]}}, merged[15:0]} : merged;
        end
      end
    end
    if (res.hit) begin
      bytes_seen_next     = 3'd0;
      bytes_expected_next = 3'd0;
      partial_value_next  = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= 3'd0;
      decode_format  <= 1'b0;
      partial_value  <= 32'd0;
      bytes_expected <= 3'd0;
    end else if (step) begin
      bytes_seen     <= bytes_seen_next;
      decode_format  <= decode_format_next;
      partial_value  <= partial_value_next;
      bytes_expected <= bytes_expected_next;
    end
  end

endmodule

// ===== design/network_integer_byte_codec.sv =====
// ----------------------------------------------------------------------------
// network_integer_byte_codec
// compact signed and varint integer encoder/decoder, one item per beat
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with opcode, in_value, in_byte
// output channel: out_valid/out_stall with is_value, out_byte, out_value, last
// an item lands in the input register, then its result moves into the output
// register; decode items give zero or one value beat
// encode items give 1 to 5 byte beats, one per cycle while out_stall is low,
// last on the final one; the next item is accepted in the cycle the final byte moves out
// sustained rate is one beat per cycle while out_stall is low, set by the single output register
// when out_stall is high the output beat holds and the input register
// fills, after which in_stall rises
// reset clears both registers and the decoder: no value in progress
// ----------------------------------------------------------------------------
module network_integer_byte_codec (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_value,
  output logic [7:0]         out_byte,
  output logic signed [31:0] out_value,
  output logic               last
);
  import nibc_pkg::*;

  logic               in_full;
  opcode_t            op_r;
  logic signed [31:0] value_r;
  logic [7:0]         byte_r;
  logic [2:0]         idx;
  logic               out_ready;
  logic               fire;
  logic               is_enc;
  logic               done;
  logic               has_result;
  logic               accept;
  enc_beat_t          enc_beat;
  dec_result_t        dec_res;

  assign is_enc     = (op_r == OP_ENC_COMPACT) || (op_r == OP_ENC_VARINT);
  assign out_ready  = !out_valid || !out_stall;
  assign fire       = in_full && out_ready;
  assign done       = is_enc ? enc_beat.last : 1'b1;
  assign has_result = is_enc || dec_res.hit;
  assign in_stall   = in_full && !(fire && done);
  assign accept     = in_valid && !in_stall;

  nibc_enc u_enc (
    .varint (op_r == OP_ENC_VARINT),
    .value  (value_r),
    .idx    (idx),
    .beat   (enc_beat)
  );

  nibc_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .step      (fire && !is_enc),
    .op_varint (op_r == OP_DEC_VARINT),
    .in_byte   (byte_r),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      idx     <= 3'd0;
    end else if (accept) begin
      in_full <= 1'b1;
      idx     <= 3'd0;
    end else if (fire && done) begin
      in_full <= 1'b0;
    end else if (fire) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode_t'(opcode);
      value_r <= in_value;
      byte_r  <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (is_enc) begin
        is_value  <= 1'b0;
        out_byte  <= enc_beat.data;
        out_value <= 32'sd0;
        last      <= enc_beat.last;
      end else begin
        is_value  <= 1'b1;
        out_byte  <= 8'd0;
        out_value <= dec_res.value;
        last      <= 1'b1;
      end
    end
  end

endmodule

// ===== test/nibc_checker.sv =====
// ----------------------------------------------------------------------------
// nibc_checker
// watches both channels of the integer byte codec, predicts every output beat
// from the accepted input beats and compares the two field by field
// ----------------------------------------------------------------------------
module nibc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               is_value,
  input  logic [7:0]         out_byte,
  input  logic signed [31:0] out_value,
  input  logic               last,
  output int                 errors,
  output int                 pending
);
  import nibc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        is_value;
    logic [7:0]  data;
    logic [31:0] value;
    logic        last;
  } codec_beat_t;

  codec_beat_t beats_due[$];

  logic [2:0]  dec_seen;
  logic        dec_varint;
  logic [31:0] dec_acc;
  logic [2:0]  dec_len;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void add_byte(logic [7:0] b, logic fin);
    beats_due.push_back('{1'b0, b, 32'd0, fin});
  endfunction

  function automatic void finish_value(logic [31:0] v);
    beats_due.push_back('{1'b1, 8'd0, v, 1'b1});
    dec_seen = 3'd0;
    dec_len  = 3'd0;
    dec_acc  = 32'd0;
  endfunction

  function automatic void encode_compact(logic [31:0] v);
    logic signed [31:0] n;
    n = signed'(v);
    if (n <= SMALL_MAX && n >= SMALL_MIN) begin
      add_byte(v[7:0], 1'b1);
    end else if (n <= MID_MAX && n >= MID_MIN) begin
      add_byte(MARK_SHORT, 1'b0);
      add_byte(v[7:0], 1'b0);
      add_byte(v[15:8], 1'b1);
    end else begin
      add_byte(MARK_LONG, 1'b0);
      add_byte(v[7:0], 1'b0);
      add_byte(v[15:8], 1'b0);
      add_byte(v[23:16], 1'b0);
      add_byte(v[31:24], 1'b1);
    end
  endfunction

  function automatic void encode_varint(logic [31:0] v);
    if (v[31] || v >= VARINT_LIM3) begin
      add_byte(CONT_BIT | {1'b0, v[6:0]}, 1'b0);
      add_byte(CONT_BIT | {1'b0, v[13:7]}, 1'b0);
      add_byte(CONT_BIT | {1'b0, v[20:14]}, 1'b0);
      add_byte(v[28:21], 1'b1);
    end else if (v < VARINT_LIM1) begin
      add_byte({1'b0, v[6:0]}, 1'b1);
    end else if (v < VARINT_LIM2) begin
      add_byte(CONT_BIT | {1'b0, v[6:0]}, 1'b0);
      add_byte({1'b0, v[13:7]}, 1'b1);
    end else begin
      add_byte(CONT_BIT | {1'b0, v[6:0]}, 1'b0);
      add_byte(CONT_BIT | {1'b0, v[13:7]}, 1'b0);
      add_byte({1'b0, v[20:14]}, 1'b1);
    end
  endfunction

  function automatic void decode_compact(logic [7:0] b);
    logic [1:0] sh;
    if (dec_seen == 3'd0) begin
      if (b == MARK_SHORT || b == MARK_LONG) begin
        dec_varint = 1'b0;
        dec_len    = (b == MARK_SHORT) ? COMPACT_SHORT_LEN : COMPACT_LONG_LEN;
        dec_seen   = 3'd1;
        dec_acc    = 32'd0;
      end else begin
        finish_value({{24{b[7]}}, b});
      end
    end else begin
      sh       = dec_seen[1:0] - 2'd1;
      dec_acc  = dec_acc | ({24'd0, b} << (8 * sh));
      dec_seen = dec_seen + 3'd1;
      if (dec_seen >= dec_len) begin
        if (dec_len == COMPACT_SHORT_LEN && dec_acc[15])
          dec_acc[31:16] = 16'hFFFF;
        finish_value(dec_acc);
      end
    end
  endfunction

  function automatic void decode_varint(logic [7:0] b);
    logic [31:0] w;
    if (dec_seen == 3'd0) begin
      if (!b[7]) begin
        finish_value({24'd0, b});
      end else begin
        dec_varint = 1'b1;
        dec_len    = VARINT_MAX_LEN;
        dec_seen   = 3'd1;
        dec_acc    = {25'd0, b[6:0]};
      end
    end else if (dec_seen >= 3'd3) begin
      w = dec_acc | {3'd0, b, 21'd0};
      if (w[28])
        w[31:28] = 4'hF;
      finish_value(w);
    end else begin
      dec_acc = dec_acc | ({25'd0, b[6:0]} << (7 * dec_seen));
      if (!b[7])
        finish_value(dec_acc);
      else
        dec_seen = dec_seen + 3'd1;
    end
  endfunction

  function automatic void predict_beats(opcode_t op, logic [31:0] v, logic [7:0] b);
    logic use_varint;
    case (op)
      OP_ENC_COMPACT: encode_compact(v);
      OP_ENC_VARINT:  encode_varint(v);
      default: begin
        use_varint = (dec_seen != 3'd0) ? dec_varint : (op == OP_DEC_VARINT);
        if (use_varint)
          decode_varint(b);
        else
          decode_compact(b);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    codec_beat_t got;
    codec_beat_t want;
    if (rst) begin
      beats_due.delete();
      dec_seen   = 3'd0;
      dec_varint = 1'b0;
      dec_acc    = 32'd0;
      dec_len    = 3'd0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{is_value, out_byte, out_value, last};
        if (beats_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected beat: is_value=%0d byte=%02h value=%08h last=%0d",
                     got.is_value, got.data, got.value, got.last);
          errors++;
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"beat mismatch: exp is_value=%0d byte=%02h value=%08h last=%0d,",
                        " got is_value=%0d byte=%02h value=%08h last=%0d"},
                       want.is_value, want.data, want.value, want.last,
                       got.is_value, got.data, got.value, got.last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_beats(opcode_t'(opcode), in_value, in_byte);
    end
    pending = beats_due.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives the integer byte codec with directed corner items, then random
// encode items, compact or varint byte streams and lone decode bytes with random
// idling on both sides; the checker beside the block scores every output beat
// ----------------------------------------------------------------------------
module tb;
  import nibc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS      = 330;
  localparam int IDLE_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  opcode_t            opcode;
  logic signed [31:0] in_value;
  logic [7:0]         in_byte;
  logic               out_valid;
  logic               out_stall;
  logic               is_value;
  logic [7:0]         out_byte;
  logic signed [31:0] out_value;
  logic               last;

  int check_errors;
  int pending_beats;
  int n_sent;
  int idle_cycles;
  int hold_left;
  int stall_left;
  bit hold_req;
  bit tx_quiet;
  bit rx_quiet;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  network_integer_byte_codec dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .in_value  (in_value),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_value  (is_value),
    .out_byte  (out_byte),
    .out_value (out_value),
    .last      (last)
  );

  nibc_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .in_value  (in_value),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_value  (is_value),
    .out_byte  (out_byte),
    .out_value (out_value),
    .last      (last),
    .errors    (check_errors),
    .pending   (pending_beats)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 253)) - 32'd126;
      1: return 32'($urandom_range(0, 65535)) - 32'd32768;
      2: return $urandom();
      3: return 32'($urandom_range(0, (1 << 21) - 1)) >> $urandom_range(0, 20);
      4: begin
        case ($urandom_range(0, 13))
          0:  return -32'sd127;
          1:  return -32'sd126;
          2:  return 32'sd127;
          3:  return 32'sd128;
          4:  return -32'sd32768;
          5:  return -32'sd32769;
          6:  return 32'sd32767;
          7:  return 32'sd32768;
          8:  return (32'd1 << 21) - 32'd1;
          9:  return 32'd1 << 21;
          10: return 32'd1 << 28;
          11: return 32'hFFFF_FFFF;
          12: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return -32'($urandom_range(0, 1 << 22));
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(opcode_t op, logic [31:0] val, logic [7:0] byt);
    int gap;
    opcode   <= op;
    in_value <= val;
    in_byte  <= byt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    @(negedge clk);
    gap = (tx_quiet || $urandom_range(0, 99) < 65) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic feed_stream(bit varint);
    int          len;
    int          cut;
    logic [7:0]  b;
    opcode_t     op;
    if (varint) begin
      len = $urandom_range(1, 4);
    end else begin
      case ($urandom_range(0, 2))
        0: len = 1;
        1: len = 3;
        default: len = 5;
      endcase
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
    for (int i = 0; i < cut; i++) begin
      if (varint) begin
        if (i < len - 1)
          b = CONT_BIT | 8'($urandom_range(0, 127));
        else if (len == 4)
          b = 8'($urandom());
        else
          b = 8'($urandom_range(0, 127));
      end else if (i == 0) begin
        if (len == 3)
          b = MARK_SHORT;
        else if (len == 5)
          b = MARK_LONG;
        else begin
          b = 8'($urandom());
          if (b == MARK_SHORT || b == MARK_LONG)
            b = b ^ 8'h7F;
        end
      end else begin
        b = 8'($urandom());
      end
      if (i == 0)
        op = varint ? OP_DEC_VARINT : OP_DEC_COMPACT;
      else
        op = $urandom_range(0, 1) ? OP_DEC_VARINT : OP_DEC_COMPACT;
      if (i > 0 && $urandom_range(0, 9) == 0)
        send_item($urandom_range(0, 1) ? OP_ENC_VARINT : OP_ENC_COMPACT,
                  rand_value(), 8'($urandom()));
      send_item(op, $urandom(), b);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
      stall_left = gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit hold_done;
    bit drain_done;
    int pick;
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_ENC_COMPACT;
    in_value   = '0;
    in_byte    = '0;
    out_stall  = 1'b0;
    n_sent     = 0;
    idle_cycles = 0;
    hold_left  = 0;
    stall_left = 0;
    hold_req   = 1'b0;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    send_item(OP_ENC_COMPACT, 32'sd127, 8'h00);
    send_item(OP_ENC_COMPACT, -32'sd126, 8'hFF);
    send_item(OP_ENC_COMPACT, -32'sd127, 8'h00);
    send_item(OP_ENC_COMPACT, -32'sd32768, 8'hFF);
    send_item(OP_ENC_COMPACT, 32'sd32768, 8'h00);
    send_item(OP_ENC_COMPACT, 32'h8000_0000, 8'hFF);
    send_item(OP_ENC_VARINT, 32'd127, 8'h00);
    send_item(OP_ENC_VARINT, 32'd128, 8'hFF);
    send_item(OP_ENC_VARINT, 32'd1 << 14, 8'h00);
    send_item(OP_ENC_VARINT, (32'd1 << 21) - 32'd1, 8'hFF);
    send_item(OP_ENC_VARINT, 32'd1 << 21, 8'h00);
    send_item(OP_ENC_VARINT, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_DEC_COMPACT, 32'h0000_0000, 8'h7F);
    // encode item in the middle of a compact value
    send_item(OP_DEC_COMPACT, 32'hFFFF_FFFF, MARK_SHORT);
    send_item(OP_ENC_VARINT, 32'd0, 8'h00);
    send_item(OP_DEC_COMPACT, 32'h0000_0000, 8'hFF);
    send_item(OP_DEC_COMPACT, 32'hFFFF_FFFF, 8'h7F);
    // varint opcode while a compact value is open keeps the compact format
    send_item(OP_DEC_COMPACT, 32'h0000_0000, MARK_LONG);
    send_item(OP_DEC_VARINT, 32'hFFFF_FFFF, 8'h00);
    send_item(OP_DEC_VARINT, 32'h0000_0000, 8'h00);
    send_item(OP_DEC_VARINT, 32'hFFFF_FFFF, 8'h00);
    send_item(OP_DEC_VARINT, 32'h0000_0000, 8'h80);
    // four-byte varint, fourth byte taken whole
    repeat (4) send_item(OP_DEC_VARINT, 32'hFFFF_FFFF, 8'hFF);

    while (n_sent < ITEMS) begin
      if (n_sent >= 120 && !hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (n_sent >= 200 && !drain_done) begin
        drain_done = 1'b1;
        in_valid <= 1'b0;
        wait (pending_beats == 0);
        @(negedge clk);
      end
      tx_quiet = (n_sent >= 120 && n_sent < 170) || (n_sent >= 230 && n_sent < 280);
      rx_quiet = (n_sent >= 230 && n_sent < 280);
      pick = $urandom_range(0, 99);
      if (pick < 30)
        send_item($urandom_range(0, 1) ? OP_ENC_VARINT : OP_ENC_COMPACT,
                  rand_value(), 8'($urandom()));
      else if (pick < 85)
        feed_stream($urandom_range(0, 1));
      else
        send_item($urandom_range(0, 1) ? OP_DEC_VARINT : OP_DEC_COMPACT,
                  $urandom(), 8'($urandom()));
    end

    in_valid <= 1'b0;
    wait (pending_beats == 0);
    repeat (8) @(posedge clk);
    if (check_errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
